// ===== rtl/keyed_slot_filter_table_unit_defines.svh =====
// ----------------------------------------------------------------------------
// keyed_slot_filter_table_unit_defines
// Assertion macros shared by the filter table checker.
// ----------------------------------------------------------------------------
`ifndef KEYED_SLOT_FILTER_TABLE_UNIT_DEFINES_SVH
`define KEYED_SLOT_FILTER_TABLE_UNIT_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define KSFT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication built on the macro above.
`define KSFT_ASSERT_IMP(lbl, ante, cons, msg) \
    `KSFT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/ksft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksft_pkg
// Types, codes and sizes shared by the keyed slot filter table.
// ----------------------------------------------------------------------------
package ksft_pkg;

    localparam int SLOTS        = 8;
    localparam int RECORD_WIDTH = 64;

    localparam int REQ_W       = 3;
    localparam int ID_W        = 8;
    localparam int BODY_W      = 64;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 4;

    // Slot index, and a pointer/count that can also hold SLOTS itself
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W  = $clog2(SLOTS + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 3'd0,
        REQ_GET    = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_NEXT   = 3'd3,
        REQ_REWIND = 3'd4
    } req_code_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_KEY,
        S_SCAN_FREE,
        S_SCAN_NEXT
    } state_t;

    typedef enum logic [1:0] {
        PROBE_KEY,
        PROBE_FREE,
        PROBE_USED
    } probe_mode_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ID_W-1:0]   filter_id;
        logic [BODY_W-1:0] filter_body;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ID_W-1:0]        found_id;
        logic [BODY_W-1:0]      found_body;
        logic [COUNT_OUT_W-1:0] filter_count;
    } rsp_t;

    typedef struct packed {
        logic                    set;
        logic                    clr;
        logic                    rec_we;
        logic [SLOT_W-1:0]       idx;
        logic [ID_W-1:0]         key;
        logic [RECORD_WIDTH-1:0] rec;
    } store_cmd_t;

endpackage

// ===== rtl/keyed_slot_filter_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_filter_table_unit
// Eight-slot packet filter table keyed by identifier, one slot per cycle.
// ----------------------------------------------------------------------------
// The done strobe follows dispatch for rewind, the unused codes and a next
//   with the pointer parked at SLOTS, the key scan for get, remove and replacing
//   adds, the used-slot scan for next, and key scan then free scan for a new add.
// Throughput: one item at a time; start may be raised in the strobe cycle.
// Each scan walks the slots through the single probe compare.
// Reset: clears valid marks, count and scan pointer at once; no clear pass.
// The receiver cannot stall: the done strobe is high for exactly one cycle.
module keyed_slot_filter_table_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ksft_pkg::req_t req,
    output logic           done,
    output ksft_pkg::rsp_t rsp
);
    import ksft_pkg::*;

    store_cmd_t              cmd;
    logic [SLOT_W-1:0]       rd_idx;
    logic                    rd_valid;
    logic [ID_W-1:0]         rd_key;
    logic [RECORD_WIDTH-1:0] rd_rec;
    probe_mode_t             mode;
    logic                    hit;

    // Sequencer: hold the item, advance the slot index, build the result
    ksft_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .busy   (busy),
        .done   (done),
        .rsp    (rsp),
        .cmd    (cmd),
        .rd_idx (rd_idx),
        .mode   (mode),
        .hit    (hit),
        .rd_key (rd_key),
        .rd_rec (rd_rec)
    );

    // Slot storage: valid marks reset, keys and records written on demand
    ksft_slot_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_idx   (rd_idx),
        .rd_valid (rd_valid),
        .rd_key   (rd_key),
        .rd_rec   (rd_rec)
    );

    // Shared compare: tests the addressed slot for the current scan against
    // the key held with the item, since the input may move on while busy
    ksft_probe u_probe (
        .mode     (mode),
        .rd_valid (rd_valid),
        .rd_key   (rd_key),
        .key      (cmd.key),
        .hit      (hit)
    );

endmodule

// ===== rtl/ksft_slot_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksft_slot_store
// Slot storage: valid marks, keys and records with one write and one read.
// ----------------------------------------------------------------------------
module ksft_slot_store (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ksft_pkg::store_cmd_t             cmd,
    input  logic [ksft_pkg::SLOT_W-1:0]      rd_idx,
    output logic                             rd_valid,
    output logic [ksft_pkg::ID_W-1:0]        rd_key,
    output logic [ksft_pkg::RECORD_WIDTH-1:0] rd_rec
);
    import ksft_pkg::*;

    logic [SLOTS-1:0]        valid_reg;
    logic [SLOTS-1:0]        valid_next;
    logic [ID_W-1:0]         key_reg [SLOTS];
    logic [RECORD_WIDTH-1:0] rec_reg [SLOTS];

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.set)
        begin
            valid_next[cmd.idx] = 1'b1;
        end
        if (cmd.clr)
        begin
            valid_next[cmd.idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Keys and records are only read behind a valid mark
    always_ff @(posedge clk)
    begin
        if (cmd.set)
        begin
            key_reg[cmd.idx] <= cmd.key;
        end
        if (cmd.set || cmd.rec_we)
        begin
            rec_reg[cmd.idx] <= cmd.rec;
        end
    end

    assign rd_valid = valid_reg[rd_idx];
    assign rd_key   = key_reg[rd_idx];
    assign rd_rec   = rec_reg[rd_idx];

endmodule

// ===== rtl/ksft_probe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksft_probe
// Shared slot test: key match, free slot or used slot.
// ----------------------------------------------------------------------------
module ksft_probe (
    input  ksft_pkg::probe_mode_t       mode,
    input  logic                        rd_valid,
    input  logic [ksft_pkg::ID_W-1:0]   rd_key,
    input  logic [ksft_pkg::ID_W-1:0]   key,
    output logic                        hit
);
    import ksft_pkg::*;

    always_comb
    begin
        case (mode)
            PROBE_KEY:  hit = rd_valid && (rd_key == key);
            PROBE_FREE: hit = !rd_valid;
            PROBE_USED: hit = rd_valid;
            default:    hit = 1'b0;
        endcase
    end

endmodule

// ===== rtl/ksft_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksft_ctrl
// Sequencer: walks the slots one per cycle and builds the result item.
// ----------------------------------------------------------------------------
module ksft_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  ksft_pkg::req_t                    req,
    output logic                              busy,
    output logic                              done,
    output ksft_pkg::rsp_t                    rsp,
    output ksft_pkg::store_cmd_t              cmd,
    output logic [ksft_pkg::SLOT_W-1:0]       rd_idx,
    output ksft_pkg::probe_mode_t             mode,
    input  logic                              hit,
    input  logic [ksft_pkg::ID_W-1:0]         rd_key,
    input  logic [ksft_pkg::RECORD_WIDTH-1:0] rd_rec
);
    import ksft_pkg::*;

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [PTR_W-1:0]   count_reg, count_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            ptr_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        logic                    last;
        logic                    fin;
        status_t                 fin_status;
        logic [ID_W-1:0]         fin_id;
        logic [BODY_W-1:0]       fin_body;

        last       = (idx_reg == SLOT_W'(SLOTS - 1));
        fin        = 1'b0;
        fin_status = STS_OK;
        fin_id     = '0;
        fin_body   = '0;

        state_next = state_reg;
        req_next   = req_reg;
        idx_next   = idx_reg;
        ptr_next   = ptr_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        mode       = PROBE_KEY;

        cmd        = '0;
        cmd.idx    = idx_reg;
        cmd.key    = req_reg.filter_id;
        cmd.rec    = req_reg.filter_body[RECORD_WIDTH-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                idx_next = '0;
                if (req_reg.req_type inside {REQ_ADD, REQ_GET, REQ_REMOVE})
                begin
                    state_next = S_SCAN_KEY;
                end
                else
                begin
                    case (req_reg.req_type)
                        REQ_NEXT:
                        begin
                            if (ptr_reg >= PTR_W'(SLOTS))
                            begin
                                fin        = 1'b1;
                                fin_status = STS_NOT_FOUND;
                            end
                            else
                            begin
                                idx_next   = ptr_reg[SLOT_W-1:0];
                                state_next = S_SCAN_NEXT;
                            end
                        end
                        REQ_REWIND:
                        begin
                            ptr_next = '0;
                            fin      = 1'b1;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN_KEY:
            begin
                mode = PROBE_KEY;
                if (hit)
                begin
                    fin = 1'b1;
                    case (req_reg.req_type)
                        REQ_ADD:
                        begin
                            cmd.rec_we = 1'b1;
                        end
                        REQ_GET:
                        begin
                            fin_id   = rd_key;
                            fin_body = BODY_W'(rd_rec);
                        end
                        REQ_REMOVE:
                        begin
                            cmd.clr    = 1'b1;
                            count_next = count_reg - PTR_W'(1);
                            ptr_next   = '0;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
                else if (last)
                begin
                    if (req_reg.req_type == REQ_ADD)
                    begin
                        if (count_reg >= PTR_W'(SLOTS))
                        begin
                            fin        = 1'b1;
                            fin_status = STS_FULL;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_SCAN_FREE;
                        end
                    end
                    else
                    begin
                        fin        = 1'b1;
                        fin_status = STS_NOT_FOUND;
                    end
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            S_SCAN_FREE:
            begin
                mode = PROBE_FREE;
                if (hit)
                begin
                    cmd.set    = 1'b1;
                    count_next = count_reg + PTR_W'(1);
                    ptr_next   = '0;
                    fin        = 1'b1;
                end
                else if (last)
                begin
                    fin        = 1'b1;
                    fin_status = STS_FULL;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            S_SCAN_NEXT:
            begin
                mode = PROBE_USED;
                if (hit)
                begin
                    fin_id   = rd_key;
                    fin_body = BODY_W'(rd_rec);
                    ptr_next = PTR_W'(idx_reg) + PTR_W'(1);
                    fin      = 1'b1;
                end
                else if (last)
                begin
                    fin        = 1'b1;
                    fin_status = STS_NOT_FOUND;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next            = S_IDLE;
            done_next             = 1'b1;
            rsp_next.status       = fin_status;
            rsp_next.found_id     = fin_id;
            rsp_next.found_body   = fin_body;
            rsp_next.filter_count = COUNT_OUT_W'(count_next);
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;
    assign rd_idx = idx_reg;

endmodule

// ===== rtl/ksft_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksft_checker
// Port-level checks on the filter table, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyed_slot_filter_table_unit_defines.svh"

module ksft_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input ksft_pkg::req_t req,
    input logic           done,
    input ksft_pkg::rsp_t rsp
);
    import ksft_pkg::*;

    `KSFT_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while busy")
    `KSFT_ASSERT_IMP(a_fell_done, $fell(busy), done, "item finished without a result")
    `KSFT_ASSERT_IMP(a_miss_zero, done && (rsp.status != STS_OK), (rsp.found_id == '0) && (rsp.found_body == '0), "entry fields not cleared on a miss")
    `KSFT_ASSERT_IMP(a_count_max, done, rsp.filter_count <= COUNT_OUT_W'(SLOTS), "count above table size")
    `KSFT_ASSERT(a_rewind_lat, (start && !busy && (req.req_type == REQ_REWIND)) |-> ##2 (done && (rsp.status == STS_OK)), "rewind result late or not ok")

endmodule

bind keyed_slot_filter_table_unit ksft_checker u_ksft_checker (.*);

// ===== tb/keyed_slot_filter_table_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_filter_table_unit_test
// Drives add, get, remove, next, rewind and spare request codes into the
// filter table with random pacing. Every response is checked, one field at a
// time, against a local slot table kept in step with each accepted item.
// ----------------------------------------------------------------------------
module keyed_slot_filter_table_unit_test;

    import ksft_pkg::*;

    // Request codes past rewind carry no operation; they must answer ok
    localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

    // The ceiling below leaves several times the margin needed for the slowest
    // items with the longest gaps, over ~1500 items.
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int QUIET_CYCLES  = 2 * SLOTS + 4;
    localparam int KEY_POOL_LAST = 11;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    req_t req   = '0;
    rsp_t rsp;

    // Items waiting to be offered, and answers waiting to come back
    req_t pending_requests[$];
    rsp_t awaited_answers[$];

    // Local copy of the slot table
    logic                    slot_used [SLOTS];
    logic [ID_W-1:0]         slot_id   [SLOTS];
    logic [RECORD_WIDTH-1:0] slot_rec  [SLOTS];
    int                      used_total = 0;
    int                      walk_ptr   = 0;

    // Handshake bookkeeping and run statistics
    int presented_total = 0;
    int accepted_total  = 0;
    int directed_total  = 0;
    int gap_left        = 0;
    int burst_left      = 0;
    bit drain_armed     = 1'b0;
    int drains          = 0;
    int mismatches      = 0;
    int cycles          = 0;
    int op_seen [8];
    int full_seen       = 0;
    int miss_seen       = 0;

    keyed_slot_filter_table_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Table predictor: apply one accepted request to the local slot table
    // and return the answer the block must give for it.
    // ------------------------------------------------------------------
    function automatic rsp_t model_request(req_t r);
        rsp_t a;
        int   hit;
        int   free_slot;
        int   k;
        a        = '0;
        a.status = STS_OK;
        hit       = SLOTS;
        free_slot = SLOTS;
        // Lowest valid slot with this key, and lowest free slot
        for (k = SLOTS - 1; k >= 0; k--)
        begin
            if (slot_used[k] && slot_id[k] == r.filter_id)
                hit = k;
            if (!slot_used[k])
                free_slot = k;
        end
        case (r.req_type)
            REQ_ADD:
            begin
                if (hit < SLOTS)
                    slot_rec[hit] = r.filter_body[RECORD_WIDTH-1:0];
                else if (used_total >= SLOTS || free_slot == SLOTS)
                    a.status = STS_FULL;
                else
                begin
                    // Take the lowest free slot and rewind the scan
                    slot_used[free_slot] = 1'b1;
                    slot_id[free_slot]   = r.filter_id;
                    slot_rec[free_slot]  = r.filter_body[RECORD_WIDTH-1:0];
                    used_total++;
                    walk_ptr = 0;
                end
            end
            REQ_GET:
            begin
                if (hit < SLOTS)
                begin
                    a.found_id   = slot_id[hit];
                    a.found_body = BODY_W'(slot_rec[hit]);
                end
                else
                    a.status = STS_NOT_FOUND;
            end
            REQ_REMOVE:
            begin
                if (hit < SLOTS)
                begin
                    slot_used[hit] = 1'b0;
                    if (used_total > 0)
                        used_total--;
                    walk_ptr = 0;
                end
                else
                    a.status = STS_NOT_FOUND;
            end
            REQ_NEXT:
            begin
                // Pointer parked at SLOTS finds nothing and stays put
                a.status = STS_NOT_FOUND;
                for (k = walk_ptr; k < SLOTS; k++)
                begin
                    if (slot_used[k] && a.status == STS_NOT_FOUND)
                    begin
                        a.found_id   = slot_id[k];
                        a.found_body = BODY_W'(slot_rec[k]);
                        a.status     = STS_OK;
                        walk_ptr     = k + 1;
                    end
                end
            end
            REQ_REWIND:
                walk_ptr = 0;
            default:
                ; // spare codes: no change, plain ok
        endcase
        a.filter_count = used_total[COUNT_OUT_W-1:0];
        return a;
    endfunction

    task automatic queue_request(logic [REQ_W-1:0] code, logic [ID_W-1:0] id,
                                 logic [BODY_W-1:0] body);
        req_t r;
        r.req_type    = code;
        r.filter_id   = id;
        r.filter_body = body;
        pending_requests.push_back(r);
    endtask

    function automatic logic [BODY_W-1:0] pick_body();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Mostly a small key pool so adds, hits and a full table all happen;
    // now and then any key at all
    function automatic logic [ID_W-1:0] pick_key();
        if ($urandom_range(0, 3) == 0)
            return ID_W'($urandom_range(0, 255));
        return ID_W'($urandom_range(0, KEY_POOL_LAST));
    endfunction

    // Idle cycles after an item: mostly none or short, a few long, and
    // occasional bursts with no idling at all
    function automatic int pick_gap();
        int roll;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 40)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(string name, logic [BODY_W-1:0] want,
                               logic [BODY_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge. Hold an offered item until
    // the monitor has seen it accepted, then idle or offer the next one.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && !(start && accepted_total != presented_total))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (drain_armed && awaited_answers.size() != 0)
                start <= 1'b0;   // hold off until every answer is back
            else if (pending_requests.size() != 0)
            begin
                drain_armed = 1'b0;
                req   <= pending_requests.pop_front();
                start <= 1'b1;
                presented_total++;
                gap_left = pick_gap();
                // Drain once after the directed part, then now and then
                if (presented_total == directed_total || $urandom_range(0, 149) == 0)
                begin
                    drain_armed = 1'b1;
                    drains++;
                end
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample at the rising edge. Check a strobed answer against
    // the oldest expectation first, then record any item accepted at the
    // same edge, since its answer can only come later.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        rsp_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (awaited_answers.size() == 0)
                begin
                    $display("%0t: answer with none expected, got %h", $time, rsp);
                    mismatches++;
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    check_field("status", BODY_W'(want.status), BODY_W'(rsp.status));
                    check_field("found_id", BODY_W'(want.found_id), BODY_W'(rsp.found_id));
                    check_field("found_body", want.found_body, rsp.found_body);
                    check_field("filter_count", BODY_W'(want.filter_count),
                                BODY_W'(rsp.filter_count));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                want = model_request(req);
                awaited_answers.push_back(want);
                accepted_total++;
                op_seen[req.req_type]++;
                if (want.status == STS_FULL)
                    full_seen++;
                if (want.status == STS_NOT_FOUND)
                    miss_seen++;
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycles, awaited_answers.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int random_total;
        int sel;
        int k;
        int scan_len;
        for (k = 0; k < SLOTS; k++)
            slot_used[k] = 1'b0;
        for (k = 0; k < 8; k++)
            op_seen[k] = 0;

        // Directed: empty-table lookups, fill to full, replace while full,
        // reuse of the lowest freed slot, spare codes, missing key
        queue_request(REQ_REWIND, 8'h00, '0);
        queue_request(REQ_NEXT,   8'h00, '0);
        queue_request(REQ_GET,    8'h00, '0);
        queue_request(REQ_REMOVE, 8'hFF, '1);
        queue_request(REQ_ADD,    8'h00, '0);
        queue_request(REQ_ADD,    8'hFF, '1);
        for (k = 0; k < SLOTS - 2; k++)
            queue_request(REQ_ADD, ID_W'(8'h10 + k), {$urandom, $urandom});
        queue_request(REQ_ADD,    8'h40, 64'h0123_4567_89AB_CDEF);
        queue_request(REQ_ADD,    8'hFF, 64'h5555_AAAA_5555_AAAA);
        queue_request(REQ_GET,    8'hFF, '0);
        queue_request(REQ_NEXT,   8'hA5, '1);
        queue_request(REQ_REMOVE, 8'h12, '0);
        queue_request(REQ_ADD,    8'h77, 64'hFEDC_BA98_7654_3210);
        queue_request(REQ_GET,    8'h77, '0);
        for (k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++)
            queue_request(REQ_W'(k), 8'hFF, '1);
        queue_request(REQ_GET,    8'h99, '0);
        queue_request(REQ_REWIND, 8'h5A, '1);
        queue_request(REQ_NEXT,   8'h00, '0);
        directed_total = pending_requests.size();

        // Random: mostly operations on a small key pool, with full scans
        // (rewind then nexts past the last slot) mixed in
        random_total = 0;
        while (random_total < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 6)
            begin
                scan_len = $urandom_range(3, SLOTS + 2);
                queue_request(REQ_REWIND, pick_key(), pick_body());
                for (k = 0; k < scan_len; k++)
                    queue_request(REQ_NEXT, pick_key(), pick_body());
                random_total += scan_len + 1;
            end
            else
            begin
                if (sel < 36)
                    queue_request(REQ_ADD, pick_key(), pick_body());
                else if (sel < 54)
                    queue_request(REQ_GET, pick_key(), pick_body());
                else if (sel < 72)
                    queue_request(REQ_REMOVE, pick_key(), pick_body());
                else if (sel < 88)
                    queue_request(REQ_NEXT, pick_key(), pick_body());
                else if (sel < 95)
                    queue_request(REQ_REWIND, pick_key(), pick_body());
                else
                    queue_request(REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)),
                                  pick_key(), pick_body());
                random_total++;
            end
        end

        // Release reset at a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait until everything is offered, accepted and answered
        while (pending_requests.size() != 0 || accepted_total != presented_total
               || awaited_answers.size() != 0)
            @(negedge clk);
        // Let any stray answer show up
        repeat (QUIET_CYCLES) @(posedge clk);

        $display("ran %0d items: add %0d, get %0d, remove %0d, next %0d, rewind %0d, spare %0d",
                 accepted_total, op_seen[REQ_ADD], op_seen[REQ_GET], op_seen[REQ_REMOVE],
                 op_seen[REQ_NEXT], op_seen[REQ_REWIND],
                 op_seen[5] + op_seen[6] + op_seen[7]);
        $display("table-full answers %0d, not-found answers %0d, drain pauses %0d",
                 full_seen, miss_seen, drains);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
